@@ rtl/cell_reference_signal_generator_macros.svh @@
// Assertion macros shared by the cell reference signal generator modules.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef CELL_REFERENCE_SIGNAL_GENERATOR_MACROS_SVH
`define CELL_REFERENCE_SIGNAL_GENERATOR_MACROS_SVH

// Checked only outside reset.
`define CRSG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define CRSG_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/crsg_pkg.sv @@
// Package for the cell reference signal generator: beat types, command and status
// structs, constants and the Gold sequence helper functions. No dependencies.
`timescale 1ns / 1ps

package crsg_pkg;

   localparam int MAX_RB         = 110;
   localparam int SKIP_CHIPS     = 1600;
   localparam int SKIP_PAIRS     = SKIP_CHIPS / 2;
   localparam int SKIP_PAIRS_MAX = SKIP_PAIRS + MAX_RB - 1;
   localparam int SKIP_W         = $clog2(SKIP_PAIRS_MAX + 1);
   localparam int COUNT_W        = $clog2(2 * MAX_RB);
   localparam int LFSR_W         = 31;
   localparam int CELL_W         = 9;
   localparam int RB_W           = 7;
   localparam int PROD_W         = 18;

   typedef enum logic [1:0] {
      CSR_CELL_IDENTITY   = 2'd0,
      CSR_RESOURCE_BLOCKS = 2'd1,
      CSR_NORMAL_CP       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       start_req;
      logic [4:0] slot_number;
      logic [2:0] symbol_index;
      logic [1:0] antenna_port;
   } req_type;

   typedef struct packed {
      logic [10:0] subcarrier;
      logic        i_negative;
      logic        q_negative;
      logic        last;
      logic        idle_error;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic seed;
      logic skip;
      logic emit;
   } crsg_cmd_type;

   typedef struct packed {
      logic skip_done;
      logic in_progress;
   } crsg_status_type;

   // Two steps of the first Gold register, x^31 + x^3 + 1.
   function automatic logic [LFSR_W-1:0] lfsr1_step2(input logic [LFSR_W-1:0] x);
      logic [LFSR_W-1:0] y;
      y = {x[0] ^ x[3], x[LFSR_W-1:1]};
      return {y[0] ^ y[3], y[LFSR_W-1:1]};
   endfunction

   // Two steps of the second Gold register, x^31 + x^3 + x^2 + x + 1.
   function automatic logic [LFSR_W-1:0] lfsr2_step2(input logic [LFSR_W-1:0] x);
      logic [LFSR_W-1:0] y;
      y = {x[0] ^ x[1] ^ x[2] ^ x[3], x[LFSR_W-1:1]};
      return {y[0] ^ y[1] ^ y[2] ^ y[3], y[LFSR_W-1:1]};
   endfunction

   // Remainder by six through a reciprocal multiply; exact for all 9-bit inputs.
   function automatic logic [2:0] mod6(input logic [CELL_W-1:0] c);
      logic [CELL_W+9:0] p;
      logic [CELL_W-1:0] q;
      logic [CELL_W-1:0] r;
      p = {10'd0, c} * (CELL_W + 10)'(683);
      q = {2'b00, p[CELL_W+9:12]};
      r = c - CELL_W'(q * CELL_W'(6));
      return r[2:0];
   endfunction

   // Frequency offset from port, symbol, slot parity and cell mod six.
   function automatic logic [2:0] freq_offset(input logic [1:0] port,
                                              input logic [2:0] sym,
                                              input logic       slot_odd,
                                              input logic [2:0] cell_mod);
      logic [2:0] v;
      logic [3:0] sum;
      case (port)
         2'd0:    v = (sym == 3'd0) ? 3'd0 : 3'd3;
         2'd1:    v = (sym == 3'd0) ? 3'd3 : 3'd0;
         2'd2:    v = slot_odd ? 3'd3 : 3'd0;
         default: v = slot_odd ? 3'd6 : 3'd3;
      endcase
      sum = {1'b0, v} + {1'b0, cell_mod};
      if (sum >= 4'd6) begin
         sum = sum - 4'd6;
      end
      return sum[2:0];
   endfunction

endpackage

@@ rtl/crsg_ctrl.sv @@
// Controller of the cell reference signal generator: sequences capture, seeding,
// fast-forward and emission, and owns the result valid. Depends on crsg_pkg.
`timescale 1ns / 1ps
`include "cell_reference_signal_generator_macros.svh"

module crsg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_start,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output crsg_pkg::crsg_cmd_type   cmd,
   input  crsg_pkg::crsg_status_type status
);
   import crsg_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_SKIP = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = accept && req_start;
      cmd.seed    = (state_ff == ST_LOAD);
      cmd.skip    = (state_ff == ST_SKIP);
      cmd.emit    = (accept && !req_start) || ((state_ff == ST_EMIT) && out_free);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_start) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (status.skip_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CRSG_ASSERT(a_load_to_skip, (state_ff == ST_LOAD) |=> (state_ff == ST_SKIP), "bad load exit")
   `CRSG_ASSERT(a_emit_needs_room, cmd.emit |-> out_free, "emit while result register full")
   `CRSG_ASSERT(a_emit_in_progress, (state_ff == ST_EMIT) |-> status.in_progress, "no symbol")
   `CRSG_ASSERT_ALWAYS(a_reset_state, reset |=> ((state_ff == ST_IDLE) && !rsp_valid), "not reset")

endmodule

@@ rtl/crsg_dp.sv @@
// Datapath of the cell reference signal generator: configuration registers, seed
// multiply, Gold registers, skip and element counters and the result register. Uses crsg_pkg.
`timescale 1ns / 1ps
`include "cell_reference_signal_generator_macros.svh"

module crsg_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [8:0]                csr_wdata,
   input  crsg_pkg::req_type         req_data,
   output crsg_pkg::rsp_type         rsp_data,
   input  crsg_pkg::crsg_cmd_type    cmd,
   output crsg_pkg::crsg_status_type status
);
   import crsg_pkg::*;

   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic [RB_W-1:0]    rb_ff, rb_in;
   logic               ncp_ff, ncp_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [LFSR_W-1:0]  first_ff, first_in;
   logic [LFSR_W-1:0]  second_ff, second_in;
   logic [SKIP_W-1:0]  skip_ff, skip_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [2:0]         offset_ff, offset_in;
   logic               active_ff, active_in;
   rsp_type            rsp_ff, rsp_in;

   logic [RB_W-1:0]    rb_used;
   logic [7:0]         seed_factor;
   logic               last;
   logic [10:0]        subcarrier;

   always_comb begin
      rb_used = rb_ff;
      if (rb_ff < RB_W'(1)) begin
         rb_used = RB_W'(1);
      end else if (rb_ff > RB_W'(MAX_RB)) begin
         rb_used = RB_W'(MAX_RB);
      end
   end

   always_comb begin
      cell_in = cell_ff;
      rb_in   = rb_ff;
      ncp_in  = ncp_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CELL_IDENTITY:   cell_in = csr_wdata;
            CSR_RESOURCE_BLOCKS: rb_in   = csr_wdata[RB_W-1:0];
            CSR_NORMAL_CP:       ncp_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign seed_factor = 8'(7 * ({3'd0, req_data.slot_number} + 8'd1))
                      + {5'd0, req_data.symbol_index} + 8'd1;
   assign prod_in     = PROD_W'(seed_factor) * PROD_W'({cell_ff, 1'b1});
   assign last        = ({1'b0, count_ff} + 9'd1) >= {1'b0, rb_used, 1'b0};
   assign subcarrier  = {1'b0, count_ff, 2'b00} + {2'b00, count_ff, 1'b0}
                      + {8'd0, offset_ff};

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      skip_in   = skip_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      active_in = active_ff;
      rsp_in    = rsp_ff;
      if (cmd.capture) begin
         offset_in = freq_offset(req_data.antenna_port, req_data.symbol_index,
                                 req_data.slot_number[0], mod6(cell_ff));
         count_in  = '0;
         active_in = 1'b1;
      end
      if (cmd.seed) begin
         // Seed is 1024 * factor * (2 * cell + 1) + 2 * cell + normal_cp.
         first_in  = LFSR_W'(1);
         second_in = LFSR_W'({prod_ff, cell_ff, ncp_ff});
         skip_in   = SKIP_W'(SKIP_PAIRS + MAX_RB) - SKIP_W'(rb_used);
      end
      if (cmd.skip) begin
         first_in  = lfsr1_step2(first_ff);
         second_in = lfsr2_step2(second_ff);
         skip_in   = skip_ff - SKIP_W'(1);
      end
      if (cmd.emit) begin
         rsp_in = '0;
         if (active_ff) begin
            rsp_in.subcarrier = subcarrier;
            rsp_in.i_negative = first_ff[0] ^ second_ff[0];
            rsp_in.q_negative = first_ff[1] ^ second_ff[1];
            rsp_in.last       = last;
            first_in          = lfsr1_step2(first_ff);
            second_in         = lfsr2_step2(second_ff);
            if (last) begin
               active_in = 1'b0;
               count_in  = '0;
            end else begin
               count_in  = count_ff + COUNT_W'(1);
            end
         end else begin
            rsp_in.idle_error = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff   <= '0;
         rb_ff     <= RB_W'(6);
         ncp_ff    <= 1'b1;
         first_ff  <= '0;
         second_ff <= '0;
         skip_ff   <= '0;
         count_ff  <= '0;
         offset_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         cell_ff   <= cell_in;
         rb_ff     <= rb_in;
         ncp_ff    <= ncp_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         skip_ff   <= skip_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data           = rsp_ff;
   assign status.skip_done   = (skip_ff == SKIP_W'(1));
   assign status.in_progress = active_ff;

   `CRSG_ASSERT(a_count_bound, count_ff <= COUNT_W'(2 * MAX_RB - 1), "element count past symbol end")
   `CRSG_ASSERT(a_skip_nonzero, cmd.skip |-> (skip_ff != '0), "skip counter underflow")

endmodule

@@ rtl/cell_reference_signal_generator.sv @@
// Top level of the cell reference signal generator: joins controller and datapath.
// Depends on crsg_pkg, crsg_ctrl and crsg_dp.
//
// Usage: configure cell_identity, resource_blocks and normal_cp through the csr_
// write port while the block is idle. Each request beat yields exactly one
// response beat. A beat with start_req set latches slot, symbol and antenna port,
// seeds the two Gold registers and fast-forwards them two chips per cycle, then
// returns element 0. Beats with start_req clear return the next element, with last
// set on element 2*resource_blocks-1, resource_blocks clamped to 1 to 110; with no
// symbol in progress they return idle_error set and all other fields zero.
// Timing: a continue beat is registered at its acceptance edge, so the response
// is valid the next cycle and such beats stream at one per cycle while rsp_ready
// stays high. A start beat passes through a seed load state, a fast-forward state
// that steps the Gold registers by 1820-2*resource_blocks chips, and an emit state
// that waits for a free result register; req_ready stays low meanwhile.
// A stalled response holds its beat in the output register; one further request
// is taken only when that register is free or drained in the same cycle.
// Reset clears all registers but the seed product and response data to their defaults and drops any symbol in progress.
`timescale 1ns / 1ps

module cell_reference_signal_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  crsg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output crsg_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [8:0]        csr_wdata
);
   import crsg_pkg::*;

   crsg_cmd_type    cmd;
   crsg_status_type status;

   crsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_start (req_data.start_req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   crsg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
